// ----- rtl/core/fractional_sample_interpolation_top_defines.svh -----
// Assertion macros shared by the interpolation filter RTL.
// The macros expect signals named clk and arst_n in the module that uses them.
`ifndef FRACTIONAL_SAMPLE_INTERPOLATION_TOP_DEFINES_SVH
`define FRACTIONAL_SAMPLE_INTERPOLATION_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/fsi_pkg.sv -----
`timescale 1ns / 1ps

package fsi_pkg;

	// Request operation codes.
	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Component codes.
	localparam logic COMP_LUMA   = 1'b0;
	localparam logic COMP_CHROMA = 1'b1;

	// Configuration register indexes and port widths.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_LUMA_DEPTH   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_DEPTH = 1'b1;

	// Bit depth limits and reset value.
	localparam logic [CFG_DATA_W-1:0] DEPTH_MIN   = 4'd8;
	localparam logic [CFG_DATA_W-1:0] DEPTH_MAX   = 4'd12;
	localparam logic [CFG_DATA_W-1:0] DEPTH_RESET = 4'd8;

	// Field widths fixed by the request and result formats.
	localparam int SIZE_W  = 7;
	localparam int PHASE_W = 3;
	localparam int PRED_W  = 16;
	localparam int COEF_W  = 8;
	localparam int TAPS    = 8;
	localparam int LINE_SLOTS = 7;
	localparam int PRED_MAX = 32767;
	localparam int PRED_MIN = -32768;
	localparam int V_SHIFT  = 6;

	typedef logic signed [COEF_W-1:0] coef_t;

	localparam coef_t LUMA_COEF [4][8] = '{
		'{ 8'sd0,  8'sd0,  8'sd0,   8'sd64, 8'sd0,   8'sd0,   8'sd0,  8'sd0 },
		'{-8'sd1,  8'sd4, -8'sd10,  8'sd58, 8'sd17, -8'sd5,   8'sd1,  8'sd0 },
		'{-8'sd1,  8'sd4, -8'sd11,  8'sd40, 8'sd40, -8'sd11,  8'sd4, -8'sd1 },
		'{ 8'sd0,  8'sd1, -8'sd5,   8'sd17, 8'sd58, -8'sd10,  8'sd4, -8'sd1 }
	};

	localparam coef_t CHROMA_COEF [8][4] = '{
		'{ 8'sd0, 8'sd64, 8'sd0,   8'sd0 },
		'{-8'sd2, 8'sd58, 8'sd10, -8'sd2 },
		'{-8'sd4, 8'sd54, 8'sd16, -8'sd2 },
		'{-8'sd6, 8'sd46, 8'sd28, -8'sd4 },
		'{-8'sd4, 8'sd36, 8'sd36, -8'sd4 },
		'{-8'sd4, 8'sd28, 8'sd46, -8'sd6 },
		'{-8'sd2, 8'sd16, 8'sd54, -8'sd4 },
		'{-8'sd2, 8'sd10, 8'sd58, -8'sd2 }
	};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic tap_shift;
		logic mem_read;
		logic h_mul;
		logic h_sum;
		logic h_res;
		logic v_mul;
		logic v_sum;
		logic out_load;
		logic out_last;
		logic chroma;
		logic [PHASE_W-1:0] fx;
		logic [PHASE_W-1:0] fy;
		logic [2:0] slot;
	} fsi_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} fsi_stat_t;

	// Tap k of the eight-tap window; chroma uses only the upper four taps.
	function automatic coef_t coef_at(input logic chroma, input logic [PHASE_W-1:0] phase,
			input logic [2:0] k);
		coef_t c;
		if (chroma) begin
			c = k[2] ? CHROMA_COEF[phase][k[1:0]] : '0;
		end else begin
			c = LUMA_COEF[phase[1:0]][k];
		end
		return c;
	endfunction

	// Horizontal shift from the bit depth, with the depth clamped to 8..12.
	function automatic logic [2:0] shift_for(input logic [CFG_DATA_W-1:0] depth);
		logic [2:0] s;
		if (depth < DEPTH_MIN) begin
			s = 3'd0;
		end else if (depth > DEPTH_MAX) begin
			s = 3'(DEPTH_MAX - DEPTH_MIN);
		end else begin
			s = 3'(depth - DEPTH_MIN);
		end
		return s;
	endfunction

endpackage

// ----- rtl/core/fsi_ref_if.sv -----
`timescale 1ns / 1ps

interface fsi_ref_if #(
	parameter int SAMPLE_BITS = 12
);
	logic valid;
	logic ready;
	logic operation;
	logic component;
	logic [fsi_pkg::PHASE_W-1:0] frac_x;
	logic [fsi_pkg::PHASE_W-1:0] frac_y;
	logic [fsi_pkg::SIZE_W-1:0] block_width;
	logic [fsi_pkg::SIZE_W-1:0] block_height;
	logic [SAMPLE_BITS-1:0] ref_sample;

	modport source (
		output valid, operation, component, frac_x, frac_y, block_width, block_height,
			ref_sample,
		input ready
	);

	modport sink (
		input valid, operation, component, frac_x, frac_y, block_width, block_height,
			ref_sample,
		output ready
	);
endinterface

// ----- rtl/core/fsi_pred_if.sv -----
`timescale 1ns / 1ps

interface fsi_pred_if;
	logic valid;
	logic ready;
	logic signed [fsi_pkg::PRED_W-1:0] pred_sample;
	logic last;

	modport source (
		output valid, pred_sample, last,
		input ready
	);

	modport sink (
		input valid, pred_sample, last,
		output ready
	);
endinterface

// ----- rtl/core/fsi_datapath.sv -----
`timescale 1ns / 1ps

module fsi_datapath #(
	parameter int MAX_BLOCK_WIDTH = 64,
	parameter int SAMPLE_BITS     = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  fsi_pkg::fsi_cmd_t cmd,
	output fsi_pkg::fsi_stat_t stat,
	input  logic [$clog2(MAX_BLOCK_WIDTH)-1:0] mem_addr,
	input  logic [SAMPLE_BITS-1:0] ref_sample,
	input  logic [fsi_pkg::CFG_DATA_W-1:0] luma_depth,
	input  logic [fsi_pkg::CFG_DATA_W-1:0] chroma_depth,
	output logic pred_valid,
	input  logic pred_ready,
	output logic signed [fsi_pkg::PRED_W-1:0] pred_sample,
	output logic pred_last
);
	import fsi_pkg::*;

	localparam int HP_W = SAMPLE_BITS + COEF_W + 1;
	localparam int HS_W = HP_W + 3;
	localparam int VP_W = PRED_W + COEF_W;
	localparam int VS_W = VP_W + 3;
	localparam logic signed [HS_W-1:0] H_HI = HS_W'(PRED_MAX);
	localparam logic signed [HS_W-1:0] H_LO = HS_W'(PRED_MIN);
	localparam logic signed [VS_W-1:0] V_HI = VS_W'(PRED_MAX);
	localparam logic signed [VS_W-1:0] V_LO = VS_W'(PRED_MIN);

	logic [SAMPLE_BITS-1:0] taps_q [TAPS];
	logic signed [HP_W-1:0] hprod_q [TAPS];
	logic signed [HS_W-1:0] hsum_q;
	logic signed [PRED_W-1:0] h_q;
	logic signed [PRED_W-1:0] line_mem [LINE_SLOTS][MAX_BLOCK_WIDTH];
	logic signed [PRED_W-1:0] rd_q [LINE_SLOTS];
	logic signed [VP_W-1:0] vprod_q [TAPS];
	logic signed [VS_W-1:0] vsum_q;
	logic out_valid_q;
	logic signed [PRED_W-1:0] pred_q;
	logic last_q;

	logic signed [HS_W-1:0] hsum_c;
	logic signed [HS_W-1:0] hshift_c;
	logic signed [PRED_W-1:0] h_c;
	logic signed [PRED_W-1:0] hv_c [TAPS];
	logic signed [VS_W-1:0] vsum_c;
	logic signed [VS_W-1:0] vshift_c;
	logic signed [PRED_W-1:0] v_c;
	logic [2:0] shift1_c;

	// Tap line of the current window row; the newest sample enters at the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				taps_q[k] <= '0;
			end
		end else if (cmd.tap_shift) begin
			for (int k = 0; k < TAPS - 1; k++) begin
				taps_q[k] <= taps_q[k + 1];
			end
			taps_q[TAPS - 1] <= ref_sample;
		end
	end

	// Horizontal pass: products, then the adder tree, then shift and saturate.
	always_ff @(posedge clk) begin
		if (cmd.h_mul) begin
			for (int k = 0; k < TAPS; k++) begin
				hprod_q[k] <= HP_W'($signed({1'b0, taps_q[k]}))
					* HP_W'(coef_at(cmd.chroma, cmd.fx, 3'(k)));
			end
		end
		if (cmd.h_sum) begin
			hsum_q <= hsum_c;
		end
		if (cmd.h_res) begin
			h_q <= h_c;
		end
	end

	always_comb begin
		hsum_c = '0;
		for (int k = 0; k < TAPS; k++) begin
			hsum_c = hsum_c + HS_W'(hprod_q[k]);
		end
	end

	assign shift1_c = cmd.chroma ? shift_for(chroma_depth) : shift_for(luma_depth);
	assign hshift_c = hsum_q >>> shift1_c;

	always_comb begin
		if (hshift_c > H_HI) begin
			h_c = PRED_W'(PRED_MAX);
		end else if (hshift_c < H_LO) begin
			h_c = PRED_W'(PRED_MIN);
		end else begin
			h_c = hshift_c[PRED_W-1:0];
		end
	end

	// Seven line banks, one per window row modulo seven, all read at the same column.
	always_ff @(posedge clk) begin
		for (int b = 0; b < LINE_SLOTS; b++) begin
			if (cmd.h_res && cmd.slot == 3'(b)) begin
				line_mem[b][mem_addr] <= h_c;
			end
			if (cmd.mem_read) begin
				rd_q[b] <= line_mem[b][mem_addr];
			end
		end
	end

	// Rows row-7 .. row-1 sit in banks (slot + k) mod 7; the current row comes from h_q.
	always_comb begin
		logic [3:0] idx;
		logic [3:0] wrap;
		for (int k = 0; k < TAPS - 1; k++) begin
			idx = {1'b0, cmd.slot} + 4'(k);
			wrap = (idx >= 4'(LINE_SLOTS)) ? idx - 4'(LINE_SLOTS) : idx;
			hv_c[k] = rd_q[wrap[2:0]];
		end
		hv_c[TAPS - 1] = h_q;
	end

	// Vertical pass.
	always_ff @(posedge clk) begin
		if (cmd.v_mul) begin
			for (int k = 0; k < TAPS; k++) begin
				vprod_q[k] <= VP_W'(hv_c[k]) * VP_W'(coef_at(cmd.chroma, cmd.fy, 3'(k)));
			end
		end
		if (cmd.v_sum) begin
			vsum_q <= vsum_c;
		end
	end

	always_comb begin
		vsum_c = '0;
		for (int k = 0; k < TAPS; k++) begin
			vsum_c = vsum_c + VS_W'(vprod_q[k]);
		end
	end

	assign vshift_c = vsum_q >>> V_SHIFT;

	always_comb begin
		if (vshift_c > V_HI) begin
			v_c = PRED_W'(PRED_MAX);
		end else if (vshift_c < V_LO) begin
			v_c = PRED_W'(PRED_MIN);
		end else begin
			v_c = vshift_c[PRED_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (pred_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pred_q <= v_c;
			last_q <= cmd.out_last;
		end
	end

	assign stat.out_free = !out_valid_q || pred_ready;
	assign pred_valid = out_valid_q;
	assign pred_sample = pred_q;
	assign pred_last = last_q;

endmodule

// ----- rtl/core/fsi_ctrl.sv -----
`timescale 1ns / 1ps
`include "fractional_sample_interpolation_top_defines.svh"

module fsi_ctrl #(
	parameter int MAX_BLOCK_WIDTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  logic operation,
	input  logic component,
	input  logic [fsi_pkg::PHASE_W-1:0] frac_x,
	input  logic [fsi_pkg::PHASE_W-1:0] frac_y,
	input  logic [fsi_pkg::SIZE_W-1:0] block_width,
	input  logic [fsi_pkg::SIZE_W-1:0] block_height,
	output fsi_pkg::fsi_cmd_t cmd,
	input  fsi_pkg::fsi_stat_t stat,
	output logic [$clog2(MAX_BLOCK_WIDTH)-1:0] mem_addr
);
	import fsi_pkg::*;

	localparam int CW = $clog2(MAX_BLOCK_WIDTH + 7);
	localparam int XW = $clog2(MAX_BLOCK_WIDTH);
	localparam int RW = SIZE_W + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HMUL = 3'd1;
	localparam logic [2:0] ST_HSUM = 3'd2;
	localparam logic [2:0] ST_HRES = 3'd3;
	localparam logic [2:0] ST_VMUL = 3'd4;
	localparam logic [2:0] ST_VSUM = 3'd5;
	localparam logic [2:0] ST_VOUT = 3'd6;

	logic [2:0] state_q, state_d;
	logic open_q;
	logic chroma_q;
	logic [PHASE_W-1:0] fx_q, fy_q;
	logic [CW-1:0] last_col_q, col_q;
	logic [RW-1:0] last_row_q, row_q;
	logic [2:0] slot_q, item_slot_q;
	logic [XW-1:0] x_q;
	logic emit_v_q, is_last_q;

	logic accept, take_start, take_sample;
	logic [CW-1:0] width_c;
	logic [SIZE_W-1:0] height_c;
	logic [2:0] pad_c;
	logic emit_h_c, emit_v_c, is_last_c;

	assign req_ready = (state_q == ST_IDLE);
	assign accept = req_valid && req_ready;
	assign take_start = accept && operation == OP_START;
	assign take_sample = accept && operation == OP_SAMPLE && open_q;

	// Block size with zero taken as one and the width held to the line length.
	always_comb begin
		if (block_width == '0) begin
			width_c = CW'(1);
		end else if (int'(block_width) > MAX_BLOCK_WIDTH) begin
			width_c = CW'(MAX_BLOCK_WIDTH);
		end else begin
			width_c = CW'(block_width);
		end
		height_c = (block_height == '0) ? SIZE_W'(1) : block_height;
	end

	assign pad_c = chroma_q ? 3'd3 : 3'd7;
	assign emit_h_c = col_q >= CW'(pad_c);
	assign emit_v_c = row_q >= RW'(pad_c);
	assign is_last_c = (col_q == last_col_q) && (row_q == last_row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			open_q <= 1'b0;
			chroma_q <= COMP_LUMA;
			fx_q <= '0;
			fy_q <= '0;
			last_col_q <= '0;
			last_row_q <= '0;
			col_q <= '0;
			row_q <= '0;
			slot_q <= '0;
		end else begin
			state_q <= state_d;
			if (take_start) begin
				open_q <= 1'b1;
				chroma_q <= component;
				fx_q <= frac_x;
				fy_q <= frac_y;
				last_col_q <= width_c + ((component == COMP_CHROMA) ? CW'(2) : CW'(6));
				last_row_q <= RW'(height_c) + ((component == COMP_CHROMA) ? RW'(2) : RW'(6));
				col_q <= '0;
				row_q <= '0;
				slot_q <= '0;
			end else if (take_sample) begin
				if (is_last_c) begin
					open_q <= 1'b0;
				end
				if (col_q == last_col_q) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
					slot_q <= (slot_q == 3'(LINE_SLOTS - 1)) ? 3'd0 : slot_q + 3'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// Per-item context for the filter sequence.
	always_ff @(posedge clk) begin
		if (take_sample) begin
			x_q <= XW'(col_q - CW'(pad_c));
			item_slot_q <= slot_q;
			emit_v_q <= emit_v_c;
			is_last_q <= is_last_c;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take_sample && emit_h_c) begin
					state_d = ST_HMUL;
				end
			end
			ST_HMUL: state_d = ST_HSUM;
			ST_HSUM: state_d = ST_HRES;
			ST_HRES: state_d = emit_v_q ? ST_VMUL : ST_IDLE;
			ST_VMUL: state_d = ST_VSUM;
			ST_VSUM: state_d = ST_VOUT;
			ST_VOUT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.tap_shift = take_sample;
		cmd.mem_read = (state_q == ST_HMUL);
		cmd.h_mul = (state_q == ST_HMUL);
		cmd.h_sum = (state_q == ST_HSUM);
		cmd.h_res = (state_q == ST_HRES);
		cmd.v_mul = (state_q == ST_VMUL);
		cmd.v_sum = (state_q == ST_VSUM);
		cmd.out_load = (state_q == ST_VOUT) && stat.out_free;
		cmd.out_last = is_last_q;
		cmd.chroma = chroma_q;
		cmd.fx = fx_q;
		cmd.fy = fy_q;
		cmd.slot = item_slot_q;
	end

	assign mem_addr = x_q;

	`FSI_ASSERT_NXT(a_start_opens, take_start, open_q && col_q == '0 && row_q == '0 && slot_q == '0, "start did not reset the window position")
	`FSI_ASSERT_IMP(a_slot_range, state_q != ST_IDLE, slot_q != 3'd7 && item_slot_q != 3'd7, "line slot out of range")
	`FSI_ASSERT_NXT(a_hmul_seq, state_q == ST_HMUL, state_q == ST_HSUM, "horizontal pass sequence broken")
	`FSI_ASSERT_IMP(a_load_needs_row, cmd.out_load, emit_v_q, "result loaded for a padding row")
	`FSI_ASSERT_NXT(a_last_closes, take_sample && is_last_c, !open_q, "block still open after its last sample")

endmodule

// ----- rtl/core/fractional_sample_interpolation_top.sv -----
`timescale 1ns / 1ps

// Fractional sample interpolation filter for luma (8-tap, quarter sample) and
// chroma (4-tap, eighth sample). A start request sets the component, the two
// phases and the block size; the edge-clamped reference window then streams in
// raster order, (W+7)x(H+7) samples for luma or (W+3)x(H+3) for chroma. Each
// prediction sample leaves with the window sample that completes it, as a
// signed 16-bit extended-precision value, and the last one of a block is
// flagged. A start request aborts any open block. A start, a sample in a left
// padding column or a sample with no open block leaves the controller idle; a
// sample in a top padding row runs only the horizontal pass; a sample that
// yields a prediction runs both passes and holds in the result step while the
// output is full. Each pass is eight parallel tap products, an adder tree and
// a shift and saturation, and only one request is in the filter at a time.
// Horizontal results are kept in seven line banks of MAX_BLOCK_WIDTH entries,
// one bank per window row modulo seven, all read together at the same column.
// The line banks are never cleared: luma reads only entries written earlier in
// the block, and chroma gives zero weight to rows that it reads unwritten. The
// user must write bit depth registers only while the block is idle; the block
// itself does not enforce this.

module fractional_sample_interpolation_top #(
	parameter int MAX_BLOCK_WIDTH = 64,
	parameter int SAMPLE_BITS     = 12
) (
	input  logic clk,
	input  logic arst_n,
	fsi_ref_if.sink ref_chan,
	fsi_pred_if.source pred_chan,
	input  logic cfg_we,
	input  logic [fsi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import fsi_pkg::*;

	localparam int XW = $clog2(MAX_BLOCK_WIDTH);

	logic [CFG_DATA_W-1:0] luma_depth_q;
	logic [CFG_DATA_W-1:0] chroma_depth_q;
	fsi_cmd_t cmd;
	fsi_stat_t stat;
	logic [XW-1:0] mem_addr;

	// Bit depth registers. Out-of-range values are clamped where they are used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_depth_q <= DEPTH_RESET;
			chroma_depth_q <= DEPTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LUMA_DEPTH: luma_depth_q <= cfg_wdata;
				CFG_CHROMA_DEPTH: chroma_depth_q <= cfg_wdata;
			endcase
		end
	end

	// The controller tracks the block and the window position and steps the
	// datapath through the horizontal and vertical passes.
	fsi_ctrl #(
		.MAX_BLOCK_WIDTH(MAX_BLOCK_WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(ref_chan.valid),
		.req_ready(ref_chan.ready),
		.operation(ref_chan.operation),
		.component(ref_chan.component),
		.frac_x(ref_chan.frac_x),
		.frac_y(ref_chan.frac_y),
		.block_width(ref_chan.block_width),
		.block_height(ref_chan.block_height),
		.cmd(cmd),
		.stat(stat),
		.mem_addr(mem_addr)
	);

	// The datapath holds the tap line, both filter passes, the line banks and
	// the output register.
	fsi_datapath #(
		.MAX_BLOCK_WIDTH(MAX_BLOCK_WIDTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.mem_addr(mem_addr),
		.ref_sample(ref_chan.ref_sample),
		.luma_depth(luma_depth_q),
		.chroma_depth(chroma_depth_q),
		.pred_valid(pred_chan.valid),
		.pred_ready(pred_chan.ready),
		.pred_sample(pred_chan.pred_sample),
		.pred_last(pred_chan.last)
	);

endmodule
